>>> sv/pnrrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrrc_pkg
// Shared types and constants for the nonce resync and replay check block.
// ----------------------------------------------------------------------------
package pnrrc_pkg;

  localparam int NONCE_BYTES_DEF = 16;
  localparam int NONCE_MAX_BITS  = 128;
  localparam int WORD_W          = 64;
  localparam int LEN_W           = 11;
  localparam int WIN_W           = 7;
  localparam int CNT_W           = 32;
  localparam int DELTA_W         = 9;
  localparam int CFG_IDX_W       = 2;
  localparam int HIST_DEPTH      = 256;
  localparam int HIST_W          = 8;

  localparam logic [LEN_W-1:0] MIN_LEN     = 11'd4;
  localparam logic [WIN_W-1:0] WINDOW_RST  = 7'd30;
  localparam logic signed [9:0] HALF_RANGE = 10'sd128;
  localparam logic signed [9:0] BYTE_RANGE = 10'sd256;

  localparam logic FUNC_CHECK  = 1'b0;
  localparam logic FUNC_COMMIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;

  typedef enum logic [2:0] {
    ST_CAND      = 3'd0,
    ST_SHORT     = 3'd1,
    ST_OUT_WIN   = 3'd2,
    ST_REPLAY    = 3'd3,
    ST_ACCEPTED  = 3'd4,
    ST_AUTH_FAIL = 3'd5,
    ST_NO_PEND   = 3'd6
  } status_t;

  typedef struct packed {
    status_t              status;
    logic                 restore;
    logic                 late;
    logic [DELTA_W-1:0]   lost_delta;
  } chk_t;

endpackage

>>> sv/pnrrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrrc interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pnrrc_item_if;
  import pnrrc_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [7:0]       nonce_byte;
  logic [LEN_W-1:0] packet_length;
  logic             auth_ok;
  modport source (output valid, func, nonce_byte, packet_length, auth_ok, input ready);
  modport sink   (input valid, func, nonce_byte, packet_length, auth_ok, output ready);
endinterface

interface pnrrc_result_if;
  import pnrrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [WORD_W-1:0] nonce_low;
  logic [WORD_W-1:0] nonce_high;
  logic [CNT_W-1:0]  good_count;
  logic [CNT_W-1:0]  late_count;
  logic [CNT_W-1:0]  lost_count;
  modport source (output valid, status, nonce_low, nonce_high, good_count, late_count,
                  lost_count, input ready);
  modport sink   (input valid, status, nonce_low, nonce_high, good_count, late_count,
                  lost_count, output ready);
endinterface

interface pnrrc_cfg_if;
  import pnrrc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/pnrrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pnrrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/pnrrc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrrc_classify
// Classifies a received low nonce byte and builds the candidate nonce.
// ----------------------------------------------------------------------------
module pnrrc_classify import pnrrc_pkg::*; #(
  parameter int NONCE_BYTES = NONCE_BYTES_DEF
) (
  input  logic [NONCE_BYTES*8-1:0] cur,
  input  logic [WIN_W-1:0]         win,
  input  logic [7:0]               b,
  input  logic [LEN_W-1:0]         len,
  input  logic [HIST_W-1:0]        hist,
  output chk_t                     chk,
  output logic [NONCE_BYTES*8-1:0] cand
);

  localparam int UW = (NONCE_BYTES - 1) * 8;

  logic [UW-1:0]      up;
  logic [UW-1:0]      up_sel;
  logic [7:0]         n0;
  logic [7:0]         n0_inc;
  logic signed [9:0]  raw;
  logic signed [9:0]  diff;
  logic signed [9:0]  lim;
  logic               lookup;

  always_comb begin
    up     = cur[NONCE_BYTES*8-1:8];
    n0     = cur[7:0];
    n0_inc = n0 + 8'd1;
    raw    = $signed({2'b00, b}) - $signed({2'b00, n0});
    if (raw > HALF_RANGE) begin
      diff = raw - BYTE_RANGE;
    end else if (raw < -HALF_RANGE) begin
      diff = raw + BYTE_RANGE;
    end else begin
      diff = raw;
    end
    lim    = -$signed({3'b000, win});
    up_sel = up;
    lookup = 1'b0;
    chk.status     = ST_CAND;
    chk.restore    = 1'b0;
    chk.late       = 1'b0;
    chk.lost_delta = '0;

    if (len < MIN_LEN) begin
      chk.status = ST_SHORT;
    end else if (n0_inc == b) begin
      // in order: carry on wrap, no history lookup
      if (b < n0) begin
        up_sel = up + 1'b1;
      end
    end else begin
      lookup = 1'b1;
      if (b < n0 && diff > lim && diff < 10'sd0) begin
        chk.late       = 1'b1;
        chk.restore    = 1'b1;
        chk.lost_delta = '1;
      end else if (b > n0 && diff > lim && diff < 10'sd0) begin
        chk.late       = 1'b1;
        chk.restore    = 1'b1;
        chk.lost_delta = '1;
        up_sel         = up - 1'b1;
      end else if (b > n0 && diff > 10'sd0) begin
        chk.lost_delta = {1'b0, b} - {1'b0, n0} - 9'd1;
      end else if (b < n0 && diff > 10'sd0) begin
        chk.lost_delta = 9'd256 - {1'b0, n0} + {1'b0, b} - 9'd1;
        up_sel         = up + 1'b1;
      end else begin
        chk.status = ST_OUT_WIN;
        lookup     = 1'b0;
      end
    end

    if (lookup && hist == up_sel[7:0]) begin
      chk.status = ST_REPLAY;
    end
    cand = {up_sel, b};
  end

endmodule

>>> sv/packet_nonce_resync_replay_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_nonce_resync_replay_check
// Receive nonce tracker: check requests build a candidate nonce, commit
// requests apply the cipher verdict to history, nonce and counters.
// ----------------------------------------------------------------------------
// Pipeline: history RAM read and stage 1 capture at request accept, then
//   classify/update into the output register that drives result valid.
// Throughput: one request per cycle; the history RAM read port and the single
//   update stage set that rate. Stalls only under output backpressure.
// Reset: clears counters, pending candidate, history valid bits and init config;
//   sets window to WINDOW_RST; no clearing pass, the block accepts requests right after reset.
module packet_nonce_resync_replay_check import pnrrc_pkg::*; #(
  parameter int NONCE_BYTES = NONCE_BYTES_DEF
) (
  input logic            clk,
  input logic            rst,
  pnrrc_item_if.sink     item,
  pnrrc_result_if.source result,
  pnrrc_cfg_if.sink      cfg
);

  localparam int NB_W = NONCE_BYTES * 8;

  // config
  logic [WORD_W-1:0] init_low;
  logic [WORD_W-1:0] init_high;
  logic [WIN_W-1:0]  win;

  // architectural state
  logic [NB_W-1:0]    cur_nonce;
  logic [NB_W-1:0]    pend_nonce;
  logic               pend_valid;
  logic               pend_restore;
  logic               pend_late;
  logic [DELTA_W-1:0] pend_delta;
  logic [CNT_W-1:0]   good_total;
  logic [CNT_W-1:0]   late_total;
  logic [CNT_W-1:0]   lost_total;
  logic [HIST_DEPTH-1:0] hist_vld;

  // stage 1
  logic               s1_valid;
  logic               s1_func;
  logic [7:0]         s1_byte;
  logic [LEN_W-1:0]   s1_len;
  logic               s1_ok;
  logic               fwd_hit;
  logic [HIST_W-1:0]  fwd_data;
  logic [HIST_W-1:0]  ram_rdata;
  logic [HIST_W-1:0]  hist_val;

  logic               item_fire;
  logic               s1_fire;
  logic               hist_we;
  logic [7:0]         hist_waddr;
  logic [HIST_W-1:0]  hist_wdata;

  chk_t               chk;
  logic [NB_W-1:0]    cand;
  status_t            st;
  logic [NB_W-1:0]    nonce_res;
  logic [NB_W-1:0]    cur_after;
  logic [NONCE_MAX_BITS-1:0] nonce_wide;

  assign s1_fire    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_fire;
  assign item_fire  = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign hist_waddr = pend_nonce[7:0];
  assign hist_wdata = pend_nonce[15:8];

  pnrrc_ram #(
    .WIDTH (HIST_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (item_fire),
    .raddr (item.nonce_byte),
    .rdata (ram_rdata)
  );

  // a commit writing the entry in the read cycle is forwarded
  always_comb begin
    if (fwd_hit) begin
      hist_val = fwd_data;
    end else if (hist_vld[s1_byte]) begin
      hist_val = ram_rdata;
    end else begin
      hist_val = '0;
    end
  end

  pnrrc_classify #(
    .NONCE_BYTES (NONCE_BYTES)
  ) u_classify (
    .cur  (cur_nonce),
    .win  (win),
    .b    (s1_byte),
    .len  (s1_len),
    .hist (hist_val),
    .chk  (chk),
    .cand (cand)
  );

  always_comb begin
    hist_we = 1'b0;
    if (s1_func == FUNC_CHECK) begin
      st = chk.status;
    end else if (!pend_valid) begin
      st = ST_NO_PEND;
    end else if (!s1_ok) begin
      st = ST_AUTH_FAIL;
    end else begin
      st      = ST_ACCEPTED;
      hist_we = s1_fire;
    end
    cur_after = (st == ST_ACCEPTED && !pend_restore) ? pend_nonce : cur_nonce;
    nonce_res = (st == ST_CAND) ? cand : cur_after;
    nonce_wide = NONCE_MAX_BITS'(nonce_res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_low     <= '0;
      init_high    <= '0;
      win          <= WINDOW_RST;
      cur_nonce    <= '0;
      pend_valid   <= 1'b0;
      pend_restore <= 1'b0;
      pend_late    <= 1'b0;
      pend_delta   <= '0;
      good_total   <= '0;
      late_total   <= '0;
      lost_total   <= '0;
      hist_vld     <= '0;
      s1_valid     <= 1'b0;
      fwd_hit      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (item_fire) begin
        s1_valid <= 1'b1;
        s1_func  <= item.func;
        s1_byte  <= item.nonce_byte;
        s1_len   <= item.packet_length;
        s1_ok    <= item.auth_ok;
        fwd_hit  <= hist_we && (hist_waddr == item.nonce_byte);
        fwd_data <= hist_wdata;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        result.valid      <= 1'b1;
        result.status     <= st;
        result.nonce_low  <= nonce_wide[WORD_W-1:0];
        result.nonce_high <= nonce_wide[NONCE_MAX_BITS-1:WORD_W];
        if (s1_func == FUNC_CHECK) begin
          pend_valid   <= (chk.status == ST_CAND);
          pend_nonce   <= cand;
          pend_restore <= chk.restore;
          pend_late    <= chk.late;
          pend_delta   <= chk.lost_delta;
          result.good_count <= good_total;
          result.late_count <= late_total;
          result.lost_count <= lost_total;
        end else begin
          pend_valid <= 1'b0;
          if (st == ST_ACCEPTED) begin
            hist_vld[hist_waddr] <= 1'b1;
            cur_nonce            <= cur_after;
            good_total           <= good_total + 1'b1;
            late_total           <= late_total + CNT_W'(pend_late);
            lost_total           <= lost_total + {{(CNT_W-DELTA_W){pend_delta[DELTA_W-1]}},
                                                  pend_delta};
            result.good_count    <= good_total + 1'b1;
            result.late_count    <= late_total + CNT_W'(pend_late);
            result.lost_count    <= lost_total + {{(CNT_W-DELTA_W){pend_delta[DELTA_W-1]}},
                                                  pend_delta};
          end else begin
            result.good_count <= good_total;
            result.late_count <= late_total;
            result.lost_count <= lost_total;
          end
        end
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end

      // key setup reloads the nonce and drops any candidate
      if (cfg.valid) begin
        case (cfg.index)
          REG_INIT_LOW: begin
            init_low   <= cfg.data;
            cur_nonce  <= NB_W'({init_high, cfg.data});
            pend_valid <= 1'b0;
          end
          REG_INIT_HIGH: begin
            init_high  <= cfg.data;
            cur_nonce  <= NB_W'({cfg.data, init_low});
            pend_valid <= 1'b0;
          end
          REG_WINDOW: begin
            win <= cfg.data[WIN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  a_commit_clears_pend: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_func == FUNC_COMMIT) |=> !pend_valid)
    else $error("pending candidate survived a commit");

  a_cand_sets_pend: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && st == ST_CAND && !cfg.valid) |=> pend_valid)
    else $error("candidate issued without pending state");

  a_good_step: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && st == ST_ACCEPTED) |=> good_total == $past(good_total) + 1'b1)
    else $error("accepted commit did not advance good count");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    item_fire |-> (!s1_valid || s1_fire))
    else $error("request taken while stage 1 stalled");
`endif

endmodule
